### hdl/eatrm_pkg.sv
// Package with fixed-point constants and the sin/cos pair type for the Euler angle rotation core.
`timescale 1ns / 1ps
package eatrm_pkg;
    localparam int ANG_FRAC = 14;
    localparam int OUT_WIDTH = 16;
    localparam logic [23:0] OCTANT_UNITS = 24'(45 << 14);
    localparam logic [34:0] PI180_Q40 = 35'd19190098067;
    localparam logic [31:0] Q30_ONE = 32'h4000_0000;

    // Whole degrees are biased by a multiple of 360 so that they are never negative.
    localparam logic [19:0] DEG_BIAS = 20'd131400;

    // Reciprocals rounded up; each gives an exact quotient for dividends below the
    // bound that applies (2^18 for 45, 2^30 for the Horner divisors).
    localparam logic [18:0] RECIP_45 = 19'd372828;
    localparam int RECIP_45_SH = 24;
    localparam logic [31:0] RECIP_42 = 32'd1636178018;
    localparam int RECIP_42_SH = 36;
    localparam logic [31:0] RECIP_56 = 32'd1227133514;
    localparam int RECIP_56_SH = 36;
    localparam logic [31:0] RECIP_20 = 32'd1717986919;
    localparam int RECIP_20_SH = 35;
    localparam logic [31:0] RECIP_30 = 32'd1145324613;
    localparam int RECIP_30_SH = 35;
    localparam logic [31:0] RECIP_6 = 32'd1431655766;
    localparam int RECIP_6_SH = 33;
    localparam logic [31:0] RECIP_12 = 32'd1431655766;
    localparam int RECIP_12_SH = 34;

    typedef struct packed {
        logic signed [31:0] s;
        logic signed [31:0] c;
    } sincos_t;
endpackage

### hdl/eatrm_stream_if.sv
// Valid/ready stream interface carrying a generic payload.
`timescale 1ns / 1ps
interface eatrm_stream_if #(
    parameter int WIDTH = 72
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/euler_angles_to_rotation_matrix_core.sv
// Top level of the Euler angle to rotation matrix pipeline.
//
//   channel  dir  payload
//   in_s     in   {roll_angle, yaw_angle, pitch_angle}, ANGLE_WIDTH bits each
//   out_m    out  {up_z, up_y, up_x, right_z, right_y, right_x, fwd_z, fwd_y, fwd_x}
//
// A beat is accepted in any cycle in which the output register is empty or being taken,
// so beats can follow back to back.
// The 14 stages are angle reduction, octant fold, radians, square, six Horner steps,
// sign restore, pair products, triple products and rounding.
// A stall freezes every stage; nothing is lost or repeated. Reset clears valid bits.
`timescale 1ns / 1ps
module euler_angles_to_rotation_matrix_core #(
    parameter int ANGLE_WIDTH = 24,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic clk,
    input  logic rst_n,
    eatrm_stream_if.sink   in_s,
    eatrm_stream_if.source out_m
);
    localparam int NS = 14;
    logic [NS-1:0] v_reg;
    logic adv;
    assign adv = !v_reg[NS-1] || out_m.ready;
    assign in_s.ready = adv;
    assign out_m.valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NS-2:0], in_s.valid};
    end

    // Stage 1: biased whole degrees and their quotient by 45.
    logic [18:0] u1_reg [3];
    logic [12:0] q1_reg [3];
    logic [13:0] lo1_reg [3];
    // Stage 2: octant and folded fraction.
    logic [2:0]  o2_reg [3];
    logic [19:0] f2_reg [3];
    // Stage 3: radians.
    logic [2:0]  o3_reg [3];
    logic [31:0] x3_reg [3];
    // Stage 4: x^2.
    logic [2:0]  o4_reg [3];
    logic [31:0] x4_reg [3], xx4_reg [3];
    // Horner stages 5..10.
    logic [2:0]  o5_reg [3], o6_reg [3], o7_reg [3], o8_reg [3], o9_reg [3], o10_reg [3];
    logic [31:0] x5_reg [3], x6_reg [3], x7_reg [3], x8_reg [3], x9_reg [3];
    logic [31:0] xx5_reg [3], xx6_reg [3], xx7_reg [3], xx8_reg [3], xx9_reg [3];
    logic [31:0] t5_reg [3], pt6_reg [3], t7_reg [3], pt8_reg [3], t9_reg [3], s10_reg [3];
    logic [31:0] k5_reg [3], pk6_reg [3], k7_reg [3], pk8_reg [3], k9_reg [3], k10_reg [3];
    // Stage 11: signed sin/cos.
    eatrm_pkg::sincos_t sc11_reg [3];
    // Stage 12: pair products (Q60) and Q30 factors of the triple products, two of them rounded.
    logic signed [63:0] pcyc_reg, pcys_reg, sp_reg, srcp_reg, crcy_reg, crsy_reg;
    logic signed [63:0] srsy_reg, srcy_reg, crcp_reg;
    logic signed [31:0] srsp_reg, crsp_reg, yc12_reg, ys12_reg;
    // Stage 13: triple products.
    logic signed [63:0] e13_reg [9];
    logic [eatrm_pkg::OUT_WIDTH-1:0] out_reg [9];

    function automatic logic signed [63:0] rshift(input logic signed [63:0] v,
                                                  input int sh);
        logic signed [64:0] t;
        begin
            t = 65'(v) + (65'sd1 <<< (sh - 1));
            rshift = 64'(t >>> sh);
        end
    endfunction

    function automatic logic [31:0] div_const(input logic [31:0] n,
                                              input logic [31:0] recip,
                                              input int sh);
        logic [63:0] p;
        begin
            p = 64'(n) * 64'(recip);
            div_const = 32'(p >> sh);
        end
    endfunction

    function automatic logic [eatrm_pkg::OUT_WIDTH-1:0] fin(input logic signed [63:0] q);
        logic signed [63:0] v;
        logic signed [63:0] lim;
        begin
            v = rshift(q, 60 - OUT_FRAC_BITS);
            lim = 64'sd1 <<< OUT_FRAC_BITS;
            if (v > lim)
                v = lim;
            if (v < -lim)
                v = -lim;
            fin = v[eatrm_pkg::OUT_WIDTH-1:0];
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic signed [ANGLE_WIDTH-1:0] a;
                logic signed [33:0] ae;
                logic [19:0] hi;
                logic [19:0] u;
                logic [37:0] p45;
                logic [18:0] rem;
                logic [2:0] oc;
                logic [19:0] fr;
                logic [59:0] pr;
                logic [63:0] m;
                a = in_s.data[i*ANGLE_WIDTH +: ANGLE_WIDTH];
                ae = 34'(a);
                hi = 20'(ae >>> eatrm_pkg::ANG_FRAC);
                u = hi + eatrm_pkg::DEG_BIAS;
                p45 = 38'(u[18:0]) * 38'(eatrm_pkg::RECIP_45);
                u1_reg[i] <= u[18:0];
                q1_reg[i] <= p45[eatrm_pkg::RECIP_45_SH +: 13];
                lo1_reg[i] <= ae[13:0];

                rem = u1_reg[i] - 19'(q1_reg[i]) * 19'd45;
                oc = q1_reg[i][2:0];
                fr = {rem[5:0], lo1_reg[i]};
                if (oc[0])
                    fr = 20'(eatrm_pkg::OCTANT_UNITS) - fr;
                o2_reg[i] <= oc;
                f2_reg[i] <= fr;

                pr = 60'(f2_reg[i]) * 60'(eatrm_pkg::PI180_Q40) + (60'd1 << 23);
                o3_reg[i] <= o2_reg[i];
                x3_reg[i] <= pr[55:24];

                m = 64'(x3_reg[i]) * 64'(x3_reg[i]);
                o4_reg[i] <= o3_reg[i];
                x4_reg[i] <= x3_reg[i];
                xx4_reg[i] <= m[61:30];

                o5_reg[i] <= o4_reg[i];
                x5_reg[i] <= x4_reg[i];
                xx5_reg[i] <= xx4_reg[i];
                t5_reg[i] <= eatrm_pkg::Q30_ONE - div_const(xx4_reg[i], eatrm_pkg::RECIP_42,
                                                            eatrm_pkg::RECIP_42_SH);
                k5_reg[i] <= eatrm_pkg::Q30_ONE - div_const(xx4_reg[i], eatrm_pkg::RECIP_56,
                                                            eatrm_pkg::RECIP_56_SH);

                o6_reg[i] <= o5_reg[i];
                x6_reg[i] <= x5_reg[i];
                xx6_reg[i] <= xx5_reg[i];
                m = 64'(xx5_reg[i]) * 64'(t5_reg[i]);
                pt6_reg[i] <= m[61:30];
                m = 64'(xx5_reg[i]) * 64'(k5_reg[i]);
                pk6_reg[i] <= m[61:30];

                o7_reg[i] <= o6_reg[i];
                x7_reg[i] <= x6_reg[i];
                xx7_reg[i] <= xx6_reg[i];
                t7_reg[i] <= eatrm_pkg::Q30_ONE - div_const(pt6_reg[i], eatrm_pkg::RECIP_20,
                                                            eatrm_pkg::RECIP_20_SH);
                k7_reg[i] <= eatrm_pkg::Q30_ONE - div_const(pk6_reg[i], eatrm_pkg::RECIP_30,
                                                            eatrm_pkg::RECIP_30_SH);

                o8_reg[i] <= o7_reg[i];
                x8_reg[i] <= x7_reg[i];
                xx8_reg[i] <= xx7_reg[i];
                m = 64'(xx7_reg[i]) * 64'(t7_reg[i]);
                pt8_reg[i] <= m[61:30];
                m = 64'(xx7_reg[i]) * 64'(k7_reg[i]);
                pk8_reg[i] <= m[61:30];

                o9_reg[i] <= o8_reg[i];
                x9_reg[i] <= x8_reg[i];
                xx9_reg[i] <= xx8_reg[i];
                t9_reg[i] <= eatrm_pkg::Q30_ONE - div_const(pt8_reg[i], eatrm_pkg::RECIP_6,
                                                            eatrm_pkg::RECIP_6_SH);
                k9_reg[i] <= eatrm_pkg::Q30_ONE - div_const(pk8_reg[i], eatrm_pkg::RECIP_12,
                                                            eatrm_pkg::RECIP_12_SH);

                o10_reg[i] <= o9_reg[i];
                m = 64'(x9_reg[i]) * 64'(t9_reg[i]);
                s10_reg[i] <= m[61:30];
                m = 64'(xx9_reg[i]) * 64'(k9_reg[i]);
                k10_reg[i] <= eatrm_pkg::Q30_ONE - 32'(m >> 31);

                begin
                    logic signed [31:0] sq, cq;
                    sq = o10_reg[i][0] ? k10_reg[i] : s10_reg[i];
                    cq = o10_reg[i][0] ? s10_reg[i] : k10_reg[i];
                    case (o10_reg[i][2:1])
                        2'd0: begin sc11_reg[i].s <= sq;  sc11_reg[i].c <= cq;  end
                        2'd1: begin sc11_reg[i].s <= cq;  sc11_reg[i].c <= -sq; end
                        2'd2: begin sc11_reg[i].s <= -sq; sc11_reg[i].c <= -cq; end
                        default: begin sc11_reg[i].s <= -cq; sc11_reg[i].c <= sq; end
                    endcase
                end
            end

            // index 0 pitch, 1 yaw, 2 roll
            pcyc_reg <= sc11_reg[0].c * sc11_reg[1].c;
            pcys_reg <= sc11_reg[0].c * sc11_reg[1].s;
            sp_reg   <= 64'(sc11_reg[0].s) <<< 30;
            srcp_reg <= sc11_reg[2].s * sc11_reg[0].c;
            crcp_reg <= sc11_reg[2].c * sc11_reg[0].c;
            crcy_reg <= sc11_reg[2].c * sc11_reg[1].c;
            crsy_reg <= sc11_reg[2].c * sc11_reg[1].s;
            srsy_reg <= sc11_reg[2].s * sc11_reg[1].s;
            srcy_reg <= sc11_reg[1].c * sc11_reg[2].s;
            srsp_reg <= 32'(rshift(sc11_reg[2].s * sc11_reg[0].s, 30));
            crsp_reg <= 32'(rshift(sc11_reg[2].c * sc11_reg[0].s, 30));
            yc12_reg <= sc11_reg[1].c;
            ys12_reg <= sc11_reg[1].s;

            e13_reg[0] <= pcyc_reg;
            e13_reg[1] <= pcys_reg;
            e13_reg[2] <= sp_reg;
            e13_reg[3] <= srsp_reg * yc12_reg - crsy_reg;
            e13_reg[4] <= srsp_reg * ys12_reg + crcy_reg;
            e13_reg[5] <= -srcp_reg;
            e13_reg[6] <= -(crsp_reg * yc12_reg + srsy_reg);
            e13_reg[7] <= srcy_reg - crsp_reg * ys12_reg;
            e13_reg[8] <= crcp_reg;

            for (int j = 0; j < 9; j++)
                out_reg[j] <= fin(e13_reg[j]);
        end
    end

    always_comb
    begin
        for (int j = 0; j < 9; j++)
            out_m.data[j*eatrm_pkg::OUT_WIDTH +: eatrm_pkg::OUT_WIDTH] = out_reg[j];
    end
endmodule
